[rtl/assert_macros.svh]
// assertion helpers included by the envelope core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

[rtl/cae_pkg.sv]
// ----------------------------------------------------------------------------
// cae_pkg
// Types, codes and table builder functions of the curved adsr envelope core.
// ----------------------------------------------------------------------------
package cae_pkg;

  localparam logic [2:0] STG_IDLE    = 3'd0;
  localparam logic [2:0] STG_ATTACK  = 3'd1;
  localparam logic [2:0] STG_DECAY   = 3'd2;
  localparam logic [2:0] STG_SUSTAIN = 3'd3;
  localparam logic [2:0] STG_RELEASE = 3'd4;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  localparam logic [2:0] CFG_ATTACK_RATE   = 3'd0;
  localparam logic [2:0] CFG_DECAY_RATE    = 3'd1;
  localparam logic [2:0] CFG_SUSTAIN_RATE  = 3'd2;
  localparam logic [2:0] CFG_RELEASE_RATE  = 3'd3;
  localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd4;
  localparam logic [2:0] CFG_CURVES        = 3'd5;
  localparam logic [2:0] CFG_MODE          = 3'd6;

  localparam logic [16:0] FULL_LEVEL = 17'h10000;
  localparam logic [15:0] MIN_SCALE  = 16'd410;
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
  localparam int          DIV_W      = 44;

  typedef enum logic [4:0] {
    S_WAIT, S_DIV, S_PROG, S_SHP, S_NORM, S_LGRD, S_LGMUL, S_LGSUM,
    S_EDIV, S_EXP, S_EXRD, S_EXMUL, S_EXSUM, S_CURVE, S_SUSDIV,
    S_SUSFIN, S_BLEND, S_DONE
  } state_t;

  // shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + idx/depth) in q1.24
  function automatic logic [24:0] lg_entry(input int unsigned idx, input int unsigned depth);
    logic [63:0] x;
    logic [24:0] y;
    if (idx == depth) return 25'h100_0000;
    x = (64'd1 << 30) + udiv64(64'(idx) << 30, 64'(depth));
    y = '0;
    for (int k = 0; k < 24; k++) begin
      x = (x * x) >> 30;
      y = {y[23:0], 1'b0};
      if (x >= (64'd1 << 31)) begin
        y[0] = 1'b1;
        x = x >> 1;
      end
    end
    return y;
  endfunction

  // 2^(-idx/depth) in q1.32
  function automatic logic [32:0] ex_entry(input int unsigned idx, input int unsigned depth);
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] r;
    if (idx == 0) return 33'h1_0000_0000;
    f = udiv64(64'(depth - idx) << 24, 64'(depth));
    acc = 64'd1 << 30;
    r = 64'd1 << 31;
    for (int k = 0; k < 24; k++) begin
      r = isqrt64(r << 30);
      if (f[23 - k]) acc = (acc * r) >> 30;
    end
    return 33'(acc << 1);
  endfunction

endpackage

[rtl/curved_adsr_envelope_core.sv]
// ----------------------------------------------------------------------------
// curved_adsr_envelope_core
// ADSR envelope generator with pow-shaped stage curves and sustain drift.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one operation per transfer, in_tuser = operation (tick, trigger,
//          release, reset), in_tdata = time scale, unsigned q4.12.
//  out_* : one result per operation, level q1.16 and stage code.
//  cfg_* : register writes, always ready, index selects the register.
// Timing: trigger, release, reset and an idle tick need no division. Other
//  ticks run a small sequencer around one shared multiplier and one bit-serial
//  divider: an end-of-stage tick or a straight-line curve uses one division, a
//  curved attack, decay, release or sustain tick up to two.
//  in_tready is high only while no item is being worked on.
// Reset: envelope idle at level zero, registers at their defaults; tables are
//  constant logic, so no clearing pass is needed.
// Stall: a finished result sits in the output register; the next item may be
//  taken meanwhile and its result waits until the register frees up.
`include "assert_macros.svh"

module curved_adsr_envelope_core
  import cae_pkg::*;
#(
  parameter int POW_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] time_scale
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] level, [19:17] stage, [23:20] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(POW_TABLE_DEPTH + 1);

  logic [24:0] lg_tab [POW_TABLE_DEPTH+1];
  logic [32:0] ex_tab [POW_TABLE_DEPTH+1];

  for (genvar g = 0; g <= POW_TABLE_DEPTH; g++) begin : g_tab
    assign lg_tab[g] = lg_entry(g, POW_TABLE_DEPTH);
    assign ex_tab[g] = ex_entry(g, POW_TABLE_DEPTH);
  end

  state_t state_r, state_nxt, dv_ret_r, dv_ret_nxt;

  logic [31:0] att_rate_r, dec_rate_r, sus_rate_r, rel_rate_r;
  logic [16:0] sus_level_r;
  logic [31:0] curves_r;
  logic [1:0]  mode_r;

  logic [2:0]  stage_r, stage_nxt;
  logic [16:0] level_r, level_nxt;
  logic [32:0] prog_r, prog_nxt;
  logic [16:0] start_r, start_nxt;
  logic [16:0] target_r, target_nxt;

  logic [31:0] nrm_r, nrm_nxt;
  logic [4:0]  z_r, z_nxt;
  logic [9:0]  num_r, num_nxt, den_r, den_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  w_r, w_nxt;
  logic [32:0] sh_r, sh_nxt;
  logic        sgn_r, sgn_nxt;
  logic [24:0] lga_r, lga_nxt, lgb_r, lgb_nxt;
  logic [32:0] exa_r, exa_nxt, exb_r, exb_nxt;
  logic [65:0] mul_r;
  logic [32:0] mul_a, mul_b;

  logic [DIV_W-1:0] dv_quo_r, dv_quo_nxt;
  logic [15:0]      dv_rem_r, dv_rem_nxt;
  logic [15:0]      dv_den_r, dv_den_nxt;
  logic [5:0]       dv_cnt_r, dv_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [16:0] out_level_r, out_level_nxt;
  logic [2:0]  out_stage_r, out_stage_nxt;

  // combinational helpers
  logic [15:0]       ts_in;
  logic [31:0]       rate_sel;
  logic [44:0]       prog_sum;
  logic [32:0]       sx;
  logic [7:0]        code;
  logic signed [10:0] dd;
  logic [7:0]        mag;
  logic              lin;
  logic [IW-1:0]     idx, idx1;
  logic [24:0]       lgm;
  logic [29:0]       xlog;
  logic [32:0]       exv;
  logic [32:0]       cval;
  logic [16:0]       rs;
  logic [17:0]       sus_dev;
  logic [17:0]       sus_sum;
  logic [16:0]       boff;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_WAIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_stage_r, out_level_r};

  always_comb begin
    state_nxt     = state_r;
    dv_ret_nxt    = dv_ret_r;
    stage_nxt     = stage_r;
    level_nxt     = level_r;
    prog_nxt      = prog_r;
    start_nxt     = start_r;
    target_nxt    = target_r;
    nrm_nxt       = nrm_r;
    z_nxt         = z_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    w_nxt         = w_r;
    sh_nxt        = sh_r;
    sgn_nxt       = sgn_r;
    lga_nxt       = lga_r;
    lgb_nxt       = lgb_r;
    exa_nxt       = exa_r;
    exb_nxt       = exb_r;
    dv_quo_nxt    = dv_quo_r;
    dv_rem_nxt    = dv_rem_r;
    dv_den_nxt    = dv_den_r;
    dv_cnt_nxt    = dv_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_level_nxt = out_level_r;
    out_stage_nxt = out_stage_r;
    mul_a         = '0;
    mul_b         = '0;

    ts_in = (in_tdata < MIN_SCALE) ? MIN_SCALE : in_tdata;
    case (stage_r)
      STG_ATTACK:  rate_sel = att_rate_r;
      STG_DECAY:   rate_sel = dec_rate_r;
      STG_SUSTAIN: rate_sel = sus_rate_r;
      default:     rate_sel = rel_rate_r;
    endcase
    prog_sum = {12'b0, prog_r} + {1'b0, dv_quo_r};

    // shape input and exponent of the current stage
    sx = (stage_r == STG_ATTACK || stage_r == STG_SUSTAIN) ? prog_r : ONE_Q32 - prog_r;
    case (stage_r)
      STG_ATTACK:  code = curves_r[7:0];
      STG_DECAY:   code = curves_r[15:8];
      STG_SUSTAIN: code = curves_r[23:16];
      default:     code = curves_r[31:24];
    endcase
    dd = $signed({2'b0, code, 1'b0}) - 11'sd255;
    if (stage_r == STG_ATTACK) dd = -dd;
    mag = dd[10] ? 8'((-dd)) : dd[7:0];
    lin = (mag == 8'd1);

    idx  = IW'(mul_r[65:32]);
    idx1 = idx + IW'(1);
    lgm  = lga_r + mul_r[56:32];
    xlog = {z_r + 5'd1 == 5'd0, z_r + 5'd1, 24'b0} - {5'b0, lgm};
    exv  = exa_r - mul_r[56:24];
    cval = (stage_r == STG_ATTACK || stage_r == STG_SUSTAIN) ? sh_r : ONE_Q32 - sh_r;
    rs   = {dv_rem_r, dv_quo_r[DIV_W-1]};
    sus_dev = mul_r[36:19];
    sus_sum = {1'b0, sus_level_r} + sus_dev;
    boff = mul_r[48:32];

    case (state_r)
      S_WAIT: begin
        if (in_tvalid) begin
          state_nxt = S_DONE;
          case (in_tuser)
            OP_TICK: begin
              if (stage_r != STG_IDLE) begin
                dv_quo_nxt = {rate_sel, 12'b0};
                dv_rem_nxt = '0;
                dv_den_nxt = ts_in;
                dv_cnt_nxt = 6'(DIV_W);
                dv_ret_nxt = S_PROG;
                state_nxt  = S_DIV;
              end
            end
            OP_TRIGGER: begin
              stage_nxt  = STG_ATTACK;
              start_nxt  = level_r;
              target_nxt = FULL_LEVEL;
              prog_nxt   = '0;
            end
            OP_RELEASE: begin
              if (stage_r != STG_IDLE) begin
                stage_nxt  = STG_RELEASE;
                start_nxt  = level_r;
                target_nxt = '0;
                prog_nxt   = '0;
              end
            end
            default: begin
              stage_nxt = STG_IDLE;
              level_nxt = '0;
              prog_nxt  = '0;
            end
          endcase
        end
      end
      S_DIV: begin
        if (rs >= {1'b0, dv_den_r}) begin
          dv_rem_nxt = 16'(rs - {1'b0, dv_den_r});
          dv_quo_nxt = {dv_quo_r[DIV_W-2:0], 1'b1};
        end else begin
          dv_rem_nxt = rs[15:0];
          dv_quo_nxt = {dv_quo_r[DIV_W-2:0], 1'b0};
        end
        dv_cnt_nxt = dv_cnt_r - 6'd1;
        if (dv_cnt_r == 6'd1) state_nxt = dv_ret_r;
      end
      S_PROG: begin
        state_nxt = S_SHP;
        if (stage_r == STG_SUSTAIN) begin
          prog_nxt = (prog_sum > {12'b0, ONE_Q32}) ? ONE_Q32 : prog_sum[32:0];
        end else if (prog_sum >= {12'b0, ONE_Q32}) begin
          prog_nxt = '0;
          case (stage_r)
            STG_ATTACK: begin
              stage_nxt  = STG_DECAY;
              start_nxt  = FULL_LEVEL;
              target_nxt = sus_level_r;
            end
            STG_DECAY: begin
              if (mode_r[0]) begin
                stage_nxt  = STG_ATTACK;
                start_nxt  = level_r;
                target_nxt = FULL_LEVEL;
              end else if (mode_r[1]) begin
                stage_nxt  = STG_RELEASE;
                start_nxt  = level_r;
                target_nxt = '0;
              end else begin
                // decay end into sustain keeps the level for this tick
                stage_nxt = STG_SUSTAIN;
                state_nxt = S_DONE;
              end
            end
            default: begin
              stage_nxt = STG_IDLE;
              level_nxt = '0;
              state_nxt = S_DONE;
            end
          endcase
        end else begin
          prog_nxt = prog_sum[32:0];
        end
      end
      S_SHP: begin
        num_nxt = dd[10] ? 10'd255 + 10'(3 * mag) : 10'd255;
        den_nxt = dd[10] ? 10'd255 : 10'd255 + 10'(3 * mag);
        state_nxt = S_CURVE;
        if (sx == '0) begin
          sh_nxt = '0;
        end else if (sx[32]) begin
          sh_nxt = ONE_Q32;
        end else if (lin) begin
          sh_nxt = sx;
        end else begin
          nrm_nxt   = sx[31:0];
          z_nxt     = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (nrm_r[31]) begin
          // mantissa fraction in q0.32 sits below the leading one
          mul_a     = {1'b0, nrm_r[30:0], 1'b0};
          mul_b     = 33'(POW_TABLE_DEPTH);
          state_nxt = S_LGRD;
        end else begin
          nrm_nxt = {nrm_r[30:0], 1'b0};
          z_nxt   = z_r + 5'd1;
        end
      end
      S_LGRD: begin
        rem_nxt   = mul_r[31:0];
        lga_nxt   = lg_tab[idx];
        lgb_nxt   = lg_tab[idx1];
        state_nxt = S_LGMUL;
      end
      S_LGMUL: begin
        mul_a     = {8'b0, lgb_r - lga_r};
        mul_b     = {1'b0, rem_r};
        state_nxt = S_LGSUM;
      end
      S_LGSUM: begin
        mul_a     = {3'b0, xlog};
        mul_b     = {23'b0, num_r};
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        dv_quo_nxt = mul_r[DIV_W-1:0];
        dv_rem_nxt = '0;
        dv_den_nxt = {6'b0, den_r};
        dv_cnt_nxt = 6'(DIV_W);
        dv_ret_nxt = S_EXP;
        state_nxt  = S_DIV;
      end
      S_EXP: begin
        if (dv_quo_r[DIV_W-1:29] != '0) begin
          sh_nxt    = '0;
          state_nxt = S_CURVE;
        end else begin
          w_nxt     = dv_quo_r[28:24];
          mul_a     = {9'b0, dv_quo_r[23:0]};
          mul_b     = 33'(POW_TABLE_DEPTH);
          state_nxt = S_EXRD;
        end
      end
      S_EXRD: begin
        rem_nxt   = {8'b0, mul_r[23:0]};
        exa_nxt   = ex_tab[IW'(mul_r[65:24])];
        exb_nxt   = ex_tab[IW'(mul_r[65:24]) + IW'(1)];
        state_nxt = S_EXMUL;
      end
      S_EXMUL: begin
        mul_a     = exa_r - exb_r;
        mul_b     = {9'b0, rem_r[23:0]};
        state_nxt = S_EXSUM;
      end
      S_EXSUM: begin
        sh_nxt    = exv >> w_r;
        state_nxt = S_CURVE;
      end
      S_CURVE: begin
        if (stage_r == STG_SUSTAIN) begin
          sgn_nxt   = (cval < prog_r);
          mul_a     = (cval < prog_r) ? prog_r - cval : cval - prog_r;
          mul_b     = {16'b0, sus_level_r};
          state_nxt = S_SUSDIV;
        end else begin
          sgn_nxt   = (target_r < start_r);
          mul_a     = {16'b0, (target_r < start_r) ? start_r - target_r : target_r - start_r};
          mul_b     = cval;
          state_nxt = S_BLEND;
        end
      end
      S_SUSDIV: begin
        // divide by ten as a reciprocal multiply, exact below 2^18
        mul_a     = mul_r[64:32];
        mul_b     = 33'd52429;
        state_nxt = S_SUSFIN;
      end
      S_SUSFIN: begin
        if (!sgn_r) begin
          level_nxt = (sus_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : sus_sum[16:0];
        end else if ({1'b0, sus_level_r} < sus_dev) begin
          level_nxt = '0;
        end else begin
          level_nxt = 17'({1'b0, sus_level_r} - sus_dev);
        end
        state_nxt = S_DONE;
      end
      S_BLEND: begin
        level_nxt = sgn_r ? start_r - boff : start_r + boff;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = (stage_r == STG_IDLE) ? '0 : level_r;
          out_stage_nxt = stage_r;
          state_nxt     = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      dv_ret_r    <= S_WAIT;
      stage_r     <= STG_IDLE;
      level_r     <= '0;
      prog_r      <= '0;
      start_r     <= '0;
      target_r    <= '0;
      dv_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_ret_r    <= dv_ret_nxt;
      stage_r     <= stage_nxt;
      level_r     <= level_nxt;
      prog_r      <= prog_nxt;
      start_r     <= start_nxt;
      target_r    <= target_nxt;
      dv_cnt_r    <= dv_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_rate_r  <= 32'd89478485;
      dec_rate_r  <= 32'd89478485;
      sus_rate_r  <= 32'd89478;
      rel_rate_r  <= 32'd89478485;
      sus_level_r <= FULL_LEVEL;
      curves_r    <= 32'h7F7F7F7F;
      mode_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ATTACK_RATE:   att_rate_r <= cfg_data;
        CFG_DECAY_RATE:    dec_rate_r <= cfg_data;
        CFG_SUSTAIN_RATE:  sus_rate_r <= cfg_data;
        CFG_RELEASE_RATE:  rel_rate_r <= cfg_data;
        CFG_SUSTAIN_LEVEL: begin
          sus_level_r <= (cfg_data[16:0] > FULL_LEVEL) ? FULL_LEVEL : cfg_data[16:0];
        end
        CFG_CURVES:        curves_r <= cfg_data;
        CFG_MODE:          mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    nrm_r       <= nrm_nxt;
    z_r         <= z_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    w_r         <= w_nxt;
    sh_r        <= sh_nxt;
    sgn_r       <= sgn_nxt;
    lga_r       <= lga_nxt;
    lgb_r       <= lgb_nxt;
    exa_r       <= exa_nxt;
    exb_r       <= exb_nxt;
    mul_r       <= 66'(mul_a * mul_b);
    dv_quo_r    <= dv_quo_nxt;
    dv_rem_r    <= dv_rem_nxt;
    dv_den_r    <= dv_den_nxt;
    out_level_r <= out_level_nxt;
    out_stage_r <= out_stage_nxt;
  end

  `ASSERT_ALWAYS(a_prog_range, prog_r <= ONE_Q32, "stage progress above one")
  `ASSERT_ALWAYS(a_stage_code, stage_r <= STG_RELEASE, "stage code out of range")
  `ASSERT_IMPLIES(a_idle_level, stage_r == STG_IDLE, level_r == '0, "idle with nonzero level")
  `ASSERT_IMPLIES(a_div_count, state_r == S_DIV, dv_cnt_r != '0, "divider running with no count")

endmodule

[tb/curved_adsr_envelope_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curved_adsr_envelope_core_test
// Drives operations into the envelope core under random flow control, predicts
// each level and stage with an independent fixed-point envelope model and
// compares every result transfer against it.
// ----------------------------------------------------------------------------
module curved_adsr_envelope_core_test
  import cae_pkg::*;
();

  localparam int          DEPTH       = 256;
  localparam longint      ONE         = 64'h1_0000_0000;
  localparam int          DRAIN_WAIT  = 300;
  localparam int          STALL_LIMIT = 20000;
  localparam int          ITEM_GOAL   = 1750;

  typedef struct packed {
    logic [16:0] level;
    logic [2:0]  stage;
  } env_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  curved_adsr_envelope_core uut (.*);

  // envelope model state and registers
  longint unsigned lg_tab [DEPTH+1];
  longint unsigned ex_tab [DEPTH+1];
  longint unsigned root_tab [24];
  longint unsigned rate_att, rate_dec, rate_sus, rate_rel, sus_level, curves, mode;
  logic [2:0]      env_stage;
  longint unsigned env_level, env_progress, env_start, env_target;

  env_result_t pending_results [$];
  int          mismatches;
  int          items_sent;
  int          burst_left;
  bit          no_gaps;
  bit          hold_req;
  int          hold_left;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point math ----------------
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q24(longint unsigned x);
    longint unsigned y;
    y = 0;
    for (int k = 0; k < 24; k++) begin
      x = (x * x) >> 30;
      y <<= 1;
      if (x >= (64'd1 << 31)) begin
        y |= 1;
        x >>= 1;
      end
    end
    return y;
  endfunction

  function automatic longint unsigned exp2_q30(longint unsigned f);
    longint unsigned acc;
    acc = 64'd1 << 30;
    for (int k = 0; k < 24; k++)
      if ((f >> (23 - k)) & 1) acc = (acc * root_tab[k]) >> 30;
    return acc;
  endfunction

  task automatic build_curve_tables();
    longint unsigned r;
    r = 64'd1 << 31;
    for (int k = 0; k < 24; k++) begin
      r = isqrt(r << 30);
      root_tab[k] = r;
    end
    for (int i = 0; i < DEPTH; i++)
      lg_tab[i] = log2_q24((64'd1 << 30) + ((64'(i) << 30) / DEPTH));
    lg_tab[DEPTH] = 64'd1 << 24;
    ex_tab[0] = ONE;
    for (int i = 1; i <= DEPTH; i++)
      ex_tab[i] = exp2_q30((64'(DEPTH - i) << 24) / DEPTH) << 1;
  endtask

  function automatic longint unsigned interp(longint unsigned a, longint unsigned b,
                                             longint unsigned rem, int bits);
    if (b >= a) return a + (((b - a) * rem) >> bits);
    return a - (((a - b) * rem) >> bits);
  endfunction

  function automatic longint unsigned power_q32(longint unsigned p, longint unsigned num,
                                                longint unsigned den);
    longint unsigned frac, pos, idx, lgm, e, w;
    int m;
    if (p == 0) return 0;
    if (p >= ONE) return ONE;
    m = 31;
    while (((p >> m) & 1) == 0) m--;
    frac = (p << (32 - m)) - ONE;
    pos = frac * DEPTH;
    idx = pos >> 32;
    lgm = interp(lg_tab[idx], lg_tab[idx+1], pos & 64'hFFFF_FFFF, 32);
    e = (((64'(32 - m)) << 24) - lgm) * num / den;
    w = e >> 24;
    if (w >= 32) return 0;
    pos = (e & 64'hFF_FFFF) * DEPTH;
    idx = pos >> 24;
    return interp(ex_tab[idx], ex_tab[idx+1], pos & 64'hFF_FFFF, 24) >> w;
  endfunction

  function automatic longint unsigned curve_of(longint unsigned p, logic [7:0] code, bit neg);
    int d;
    d = 2 * int'(code) - 255;
    if (neg) d = -d;
    if (d == 1 || d == -1) return p;
    if (d < 0) return power_q32(p, longint'(255 - 3 * d), 255);
    return power_q32(p, 255, longint'(255 + 3 * d));
  endfunction

  function automatic longint unsigned mix_level(longint unsigned c);
    if (env_target >= env_start) return env_start + (((env_target - env_start) * c) >> 32);
    return env_start - (((env_start - env_target) * c) >> 32);
  endfunction

  function automatic void enter_stage(logic [2:0] st, longint unsigned from,
                                      longint unsigned to);
    env_start = from;
    env_target = to;
    env_stage = st;
    env_progress = 0;
  endfunction

  function automatic void advance_tick(longint unsigned ts);
    longint unsigned rate, p, c, dev;
    longint lvl;
    if (env_stage == STG_IDLE) return;
    if (env_stage == STG_SUSTAIN) begin
      lvl = longint'(sus_level);
      env_progress += (rate_sus << 12) / ts;
      if (env_progress > ONE) env_progress = ONE;
      p = env_progress;
      c = curve_of(p, curves[23:16], 1'b0);
      if (c >= p) begin
        dev = ((c - p) * sus_level) / (10 * ONE);
        lvl += longint'(dev);
      end else begin
        dev = ((p - c) * sus_level) / (10 * ONE);
        lvl -= longint'(dev);
      end
      if (lvl < 0) lvl = 0;
      if (lvl > 65536) lvl = 65536;
      env_level = longint'(lvl);
      return;
    end
    rate = env_stage == STG_ATTACK ? rate_att : env_stage == STG_DECAY ? rate_dec : rate_rel;
    env_progress += (rate << 12) / ts;
    if (env_progress >= ONE) begin
      env_progress = ONE;
      if (env_stage == STG_ATTACK) begin
        enter_stage(STG_DECAY, 65536, sus_level);
      end else if (env_stage == STG_DECAY) begin
        if (mode[0]) enter_stage(STG_ATTACK, env_level, 65536);
        else if (mode[1]) enter_stage(STG_RELEASE, env_level, 0);
        else begin
          env_stage = STG_SUSTAIN;
          env_progress = 0;
        end
      end else begin
        env_stage = STG_IDLE;
        env_level = 0;
        env_progress = 0;
        return;
      end
    end
    p = env_progress;
    if (env_stage == STG_ATTACK)
      env_level = mix_level(curve_of(p, curves[7:0], 1'b1));
    else if (env_stage == STG_DECAY)
      env_level = mix_level(ONE - curve_of(ONE - p, curves[15:8], 1'b0));
    else if (env_stage == STG_RELEASE)
      env_level = mix_level(ONE - curve_of(ONE - p, curves[31:24], 1'b0));
  endfunction

  function automatic env_result_t predict_envelope(logic [1:0] op, logic [15:0] ts_in);
    env_result_t r;
    longint unsigned ts;
    ts = ts_in < MIN_SCALE ? 64'(MIN_SCALE) : 64'(ts_in);
    case (op)
      OP_TICK:    advance_tick(ts);
      OP_TRIGGER: enter_stage(STG_ATTACK, env_level, 65536);
      OP_RELEASE: begin
        if (env_stage != STG_IDLE) enter_stage(STG_RELEASE, env_level, 0);
      end
      default: begin
        env_stage = STG_IDLE;
        env_level = 0;
        env_progress = 0;
      end
    endcase
    r.level = env_stage == STG_IDLE ? 17'd0 : env_level[16:0];
    r.stage = env_stage;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_op(logic [1:0] op, logic [15:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = ts;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_envelope(op, ts));
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATTACK_RATE:   rate_att = data;
      CFG_DECAY_RATE:    rate_dec = data;
      CFG_SUSTAIN_RATE:  rate_sus = data;
      CFG_RELEASE_RATE:  rate_rel = data;
      CFG_SUSTAIN_LEVEL: sus_level = data[16:0] > 17'h10000 ? 65536 : 64'(data[16:0]);
      CFG_CURVES:        curves = data;
      CFG_MODE:          mode = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 600));
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom_range(1, 1000);
      default: return $urandom_range(32'h0100_0000, 32'h4000_0000);
    endcase
  endfunction

  function automatic logic [7:0] rand_curve();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(127, 128));
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_simple_ops();
    send_op(OP_TICK, 16'd4096);
    send_op(OP_RELEASE, 16'd4096);
    send_op(OP_RESET, 16'hFFFF);
    send_op(OP_TRIGGER, 16'd0);
    repeat (4) send_op(OP_TICK, 16'd0);
    send_op(OP_TRIGGER, 16'hFFFF);
    send_op(OP_TICK, 16'hFFFF);
    send_op(OP_RELEASE, 16'd409);
    repeat (3) send_op(OP_TICK, 16'd410);
    send_op(OP_RESET, 16'd4096);
    wait_drained();
  endtask

  task automatic test_stage_ends();
    write_reg(CFG_ATTACK_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_DECAY_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_SUSTAIN_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_RELEASE_RATE, 32'h4000_0000);
    write_reg(CFG_SUSTAIN_LEVEL, 32'h0001_FFFF);
    write_reg(CFG_CURVES, 32'hFF00_80FF);
    write_reg(CFG_MODE, 32'd0);
    send_op(OP_TRIGGER, 16'd4096);
    repeat (4) send_op(OP_TICK, 16'd4096);
    send_op(OP_RELEASE, 16'd4096);
    repeat (5) send_op(OP_TICK, 16'd4096);
    wait_drained();
    write_reg(CFG_SUSTAIN_LEVEL, 32'd0);
    write_reg(CFG_CURVES, 32'h0000_FF00);
    write_reg(CFG_MODE, 32'd3);
    write_reg(CFG_ATTACK_RATE, 32'd1);
    send_op(OP_TRIGGER, 16'd4096);
    repeat (3) send_op(OP_TICK, 16'hFFFF);
    wait_drained();
    write_reg(CFG_ATTACK_RATE, 32'h8000_0000);
    write_reg(CFG_MODE, 32'd2);
    write_reg(CFG_SUSTAIN_LEVEL, 32'd70000);
    send_op(OP_TRIGGER, 16'd4096);
    repeat (6) send_op(OP_TICK, 16'd4096);
    wait_drained();
  endtask

  task automatic test_random_envelopes();
    int ticks;
    while (items_sent < ITEM_GOAL) begin
      no_gaps = $urandom_range(0, 3) == 0;
      write_reg(CFG_ATTACK_RATE, rand_rate());
      write_reg(CFG_DECAY_RATE, rand_rate());
      write_reg(CFG_SUSTAIN_RATE, $urandom_range(0, 3) == 0 ? 32'($urandom) : rand_rate());
      write_reg(CFG_RELEASE_RATE, rand_rate());
      write_reg(CFG_SUSTAIN_LEVEL, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 65536));
      write_reg(CFG_CURVES, {rand_curve(), rand_curve(), rand_curve(), rand_curve()});
      write_reg(CFG_MODE, $urandom_range(0, 3));
      repeat (8) begin
        send_op(OP_TRIGGER, rand_scale());
        ticks = $urandom_range(1, 14);
        repeat (ticks) send_op(OP_TICK, rand_scale());
        if ($urandom_range(0, 3) != 0) send_op(OP_RELEASE, rand_scale());
        ticks = $urandom_range(0, 8);
        repeat (ticks) send_op(OP_TICK, rand_scale());
        // noise
        if ($urandom_range(0, 2) == 0) send_op(2'($urandom), 16'($urandom));
      end
      wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_req = 1'b1;
    send_op(OP_TRIGGER, 16'd4096);
    repeat (12) send_op(OP_TICK, 16'd4096);
    send_op(OP_RELEASE, 16'd4096);
    repeat (6) send_op(OP_TICK, 16'd4096);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      case (($time / 640) % 4)
        0:       out_tready = 1'b1;
        1:       out_tready = 1'($urandom_range(0, 1));
        2:       out_tready = $urandom_range(0, 3) == 0;
        default: out_tready = $urandom_range(0, 7) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    env_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.level = out_tdata[16:0];
      got.stage = out_tdata[19:17];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: level %0d stage %0d",
                                       got.level, got.stage);
      end else begin
        want = pending_results.pop_front();
        if (got.level !== want.level || got.stage !== want.stage) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: level exp %0d got %0d, stage exp %0d got %0d",
                     $time, want.level, got.level, want.stage, got.stage);
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_TICK;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ATTACK_RATE;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    rate_att = 89478485;
    rate_dec = 89478485;
    rate_sus = 89478;
    rate_rel = 89478485;
    sus_level = 65536;
    curves = 32'd2139062143;
    mode = 0;
    env_stage = STG_IDLE;
    env_level = 0;
    env_progress = 0;
    env_start = 0;
    env_target = 0;
    build_curve_tables();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_simple_ops();
    test_stage_ends();
    test_backpressure();
    test_random_envelopes();

    wait_drained();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cae_pkg.sv
rtl/curved_adsr_envelope_core.sv
tb/curved_adsr_envelope_core_test.sv
